[design/tpml_pkg.sv]
package tpml_pkg;

   // tree geometry
   localparam int NODE_W  = 10;
   localparam int NODES   = 1 << NODE_W;
   localparam int LEVELS  = 16;
   localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int TBL_AW  = NODE_W + LVL_W;
   localparam int TBL_DEPTH = 1 << TBL_AW;

   // field widths
   localparam int W_W   = 30;
   localparam int DEP_W = 11;

   // special values
   localparam logic [W_W-1:0]   MIN_SENTINEL = 30'd1061109567;
   localparam logic [W_W-1:0]   NO_EDGE      = 30'd1000000000;
   localparam logic [DEP_W-1:0] DEPTH_NONE   = 11'd2047;
   localparam logic [DEP_W-1:0] DEPTH_ROOT   = 11'd0;

   // one lifting table entry: 2^k ancestor and minimum edge over those steps
   typedef struct packed {
      logic [NODE_W-1:0] anc;
      logic [W_W-1:0]    jmin;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // lifting table port controls
   typedef struct packed {
      logic              we;
      logic [TBL_AW-1:0] waddr;
      entry_type         wdata;
      logic [TBL_AW-1:0] ra;
      logic [TBL_AW-1:0] rb;
   } tbl_port_type;

   // depth memory port controls
   typedef struct packed {
      logic              we;
      logic [NODE_W-1:0] waddr;
      logic [DEP_W-1:0]  wdata;
      logic [NODE_W-1:0] ra;
      logic [NODE_W-1:0] rb;
   } dep_port_type;

   // finished query result toward the output register
   typedef struct packed {
      logic           valid;
      logic [W_W-1:0] path_min;
   } rsp_push_type;

endpackage

[design/tpml_ram.sv]
module tpml_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

[design/tpml_seq.sv]
module tpml_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_mode,
   input  logic [tpml_pkg::NODE_W-1:0] req_node,
   input  logic [tpml_pkg::NODE_W-1:0] req_other_node,
   input  logic [tpml_pkg::W_W-1:0]   req_weight,
   output logic                       req_stall,
   input  logic                       out_free,
   output tpml_pkg::rsp_push_type     push,
   output tpml_pkg::tbl_port_type     tbl,
   input  tpml_pkg::entry_type        tbl_rd_a,
   input  tpml_pkg::entry_type        tbl_rd_b,
   output tpml_pkg::dep_port_type     dep,
   input  logic [tpml_pkg::DEP_W-1:0] dep_rd_a,
   input  logic [tpml_pkg::DEP_W-1:0] dep_rd_b
);
   import tpml_pkg::*;

   typedef enum logic [9:0] {
      S_CLR    = 10'b00_0000_0001,
      S_IDLE   = 10'b00_0000_0010,
      S_I_CHK  = 10'b00_0000_0100,
      S_I_LIFT = 10'b00_0000_1000,
      S_Q_SWAP = 10'b00_0001_0000,
      S_Q_UP_T = 10'b00_0010_0000,
      S_Q_UP_D = 10'b00_0100_0000,
      S_Q_CMN  = 10'b00_1000_0000,
      S_Q_FIN  = 10'b01_0000_0000,
      S_Q_OUT  = 10'b10_0000_0000
   } state_type;

   localparam logic [LVL_W-1:0]  LVL_TOP   = LVL_W'(LEVELS - 1);
   localparam logic [LVL_W-1:0]  LVL_ZERO  = '0;
   localparam logic [NODE_W-1:0] NODE_ZERO = '0;
   localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODES - 1);
   localparam entry_type         SENT_ENTRY = '{anc: NODE_ZERO, jmin: MIN_SENTINEL};

   function automatic logic [W_W-1:0] min_w(input logic [W_W-1:0] x, input logic [W_W-1:0] y);
      return (x < y) ? x : y;
   endfunction

   state_type         state_ff, state_in;
   logic [NODE_W-1:0] a_ff, a_in;
   logic [NODE_W-1:0] b_ff, b_in;
   logic [W_W-1:0]    w_ff, w_in;
   logic [LVL_W-1:0]  k_ff, k_in;
   logic [DEP_W-1:0]  db_ff, db_in;
   logic [W_W-1:0]    res_ff, res_in;
   logic [NODE_W-1:0] anc_ff, anc_in;
   logic [W_W-1:0]    cmin_ff, cmin_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic              rz_a_ff, rz_a_in;
   logic              rz_b_ff, rz_b_in;
   logic              fwd_hit_ff, fwd_hit_in;
   entry_type         fwd_data_ff, fwd_data_in;

   entry_type ta, tb;

   // node zero's rows read as the fixed sentinel entry; port a also forwards a same-cycle write
   always_comb begin
      if (rz_a_ff) begin
         ta = SENT_ENTRY;
      end else if (fwd_hit_ff) begin
         ta = fwd_data_ff;
      end else begin
         ta = tbl_rd_a;
      end
      tb = rz_b_ff ? SENT_ENTRY : tbl_rd_b;
   end

   // sequencer
   always_comb begin
      logic [DEP_W:0]    nd;
      logic [W_W-1:0]    m0;
      logic [W_W-1:0]    rnew;
      logic [NODE_W-1:0] anew;
      logic [NODE_W-1:0] bnew;
      logic              take;

      state_in  = state_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      w_in      = w_ff;
      k_in      = k_ff;
      db_in     = db_ff;
      res_in    = res_ff;
      anc_in    = anc_ff;
      cmin_in   = cmin_ff;
      clr_in    = clr_ff;
      req_stall = 1'b1;
      push      = '{valid: 1'b0, path_min: res_ff};
      tbl       = '0;
      dep       = '0;
      nd        = '0;
      m0        = '0;
      rnew      = res_ff;
      anew      = a_ff;
      bnew      = b_ff;
      take      = 1'b0;

      unique case (state_ff)
         S_CLR: begin
            dep.we    = 1'b1;
            dep.waddr = clr_ff;
            dep.wdata = (clr_ff == NODE_ZERO) ? DEPTH_ROOT : DEPTH_NONE;
            clr_in    = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_LAST) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            req_stall = 1'b0;
            dep.ra    = req_node;
            dep.rb    = req_other_node;
            if (req_valid) begin
               a_in     = req_node;
               b_in     = req_other_node;
               w_in     = req_weight;
               state_in = req_mode ? S_Q_SWAP : S_I_CHK;
            end
         end

         // insert: a is the new node, b its parent
         S_I_CHK: begin
            nd = {1'b0, dep_rd_b} + (DEP_W+1)'(1);
            if ({1'b0, dep_rd_a} <= nd) begin
               state_in = S_IDLE;
            end else begin
               m0          = (b_ff == NODE_ZERO) ? MIN_SENTINEL : w_ff;
               dep.we      = 1'b1;
               dep.waddr   = a_ff;
               dep.wdata   = nd[DEP_W-1:0];
               tbl.we      = 1'b1;
               tbl.waddr   = {a_ff, LVL_ZERO};
               tbl.wdata   = '{anc: b_ff, jmin: m0};
               tbl.ra      = {b_ff, LVL_ZERO};
               cmin_in     = m0;
               k_in        = LVL_W'(1);
               state_in    = (LEVELS == 1) ? S_IDLE : S_I_LIFT;
            end
         end

         S_I_LIFT: begin
            m0        = min_w(cmin_ff, ta.jmin);
            tbl.we    = 1'b1;
            tbl.waddr = {a_ff, k_ff};
            tbl.wdata = '{anc: ta.anc, jmin: m0};
            tbl.ra    = {ta.anc, k_ff};
            cmin_in   = m0;
            k_in      = k_ff + LVL_W'(1);
            if (k_ff == LVL_TOP) begin
               state_in = S_IDLE;
            end
         end

         // query: make a the deeper node
         S_Q_SWAP: begin
            if (dep_rd_a < dep_rd_b) begin
               anew  = b_ff;
               bnew  = a_ff;
               db_in = dep_rd_a;
            end else begin
               db_in = dep_rd_b;
            end
            a_in     = anew;
            b_in     = bnew;
            res_in   = NO_EDGE;
            k_in     = LVL_TOP;
            tbl.ra   = {anew, LVL_TOP};
            state_in = S_Q_UP_T;
         end

         S_Q_UP_T: begin
            anc_in   = ta.anc;
            cmin_in  = ta.jmin;
            dep.ra   = ta.anc;
            state_in = S_Q_UP_D;
         end

         S_Q_UP_D: begin
            take = (dep_rd_a >= db_ff);
            if (take) begin
               anew = anc_ff;
               rnew = min_w(res_ff, cmin_ff);
            end
            a_in   = anew;
            res_in = rnew;
            if (k_ff != LVL_ZERO) begin
               k_in     = k_ff - LVL_W'(1);
               tbl.ra   = {anew, k_ff - LVL_W'(1)};
               state_in = S_Q_UP_T;
            end else if (anew == b_ff) begin
               state_in = S_Q_OUT;
            end else begin
               k_in     = LVL_TOP;
               tbl.ra   = {anew, LVL_TOP};
               tbl.rb   = {b_ff, LVL_TOP};
               state_in = S_Q_CMN;
            end
         end

         S_Q_CMN: begin
            if (ta.anc != tb.anc) begin
               m0   = min_w(ta.jmin, tb.jmin);
               rnew = min_w(res_ff, m0);
               anew = ta.anc;
               bnew = tb.anc;
            end
            a_in   = anew;
            b_in   = bnew;
            res_in = rnew;
            if (k_ff != LVL_ZERO) begin
               k_in   = k_ff - LVL_W'(1);
               tbl.ra = {anew, k_ff - LVL_W'(1)};
               tbl.rb = {bnew, k_ff - LVL_W'(1)};
            end else begin
               tbl.ra   = {anew, LVL_ZERO};
               tbl.rb   = {bnew, LVL_ZERO};
               state_in = S_Q_FIN;
            end
         end

         S_Q_FIN: begin
            m0       = min_w(ta.jmin, tb.jmin);
            res_in   = min_w(res_ff, m0);
            state_in = S_Q_OUT;
         end

         S_Q_OUT: begin
            push.valid = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rz_a_in     = (tbl.ra[TBL_AW-1 -: NODE_W] == NODE_ZERO);
      rz_b_in     = (tbl.rb[TBL_AW-1 -: NODE_W] == NODE_ZERO);
      fwd_hit_in  = tbl.we && (tbl.waddr == tbl.ra);
      fwd_data_in = tbl.wdata;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      w_ff        <= w_in;
      k_ff        <= k_in;
      db_ff       <= db_in;
      res_ff      <= res_in;
      anc_ff      <= anc_in;
      cmin_ff     <= cmin_in;
      rz_a_ff     <= rz_a_in;
      rz_b_ff     <= rz_b_in;
      fwd_hit_ff  <= fwd_hit_in;
      fwd_data_ff <= fwd_data_in;
   end

endmodule

[design/tree_path_min_binary_lifting.sv]
// Channel   Direction  Ports                                         Beat
// req_      in         req_mode req_node req_other_node req_weight   valid & !stall
// rsp_      out        rsp_path_min                                  valid & !stall
//
// An insert checks the depths, then does one lifting table read-modify-write per
// level; a query orders the nodes by depth, climbs with a table read and a depth
// read per level, and one table read of both nodes per level for the common-ancestor walk.
// Every step waits for one registered read of the table or depth memory.
// After reset the depth memory is cleared entry by entry with req_stall high.
// A finished result waits in the output register; the next item is taken meanwhile.
module tree_path_min_binary_lifting (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [tpml_pkg::NODE_W-1:0] req_node,
   input  logic [tpml_pkg::NODE_W-1:0] req_other_node,
   input  logic [tpml_pkg::W_W-1:0]    req_weight,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tpml_pkg::W_W-1:0]    rsp_path_min
);
   import tpml_pkg::*;

   tbl_port_type      tbl;
   dep_port_type      dep;
   rsp_push_type      push;
   logic [ENTRY_W-1:0] tbl_rd_a_raw, tbl_rd_b_raw;
   entry_type         tbl_rd_a, tbl_rd_b;
   logic [DEP_W-1:0]  dep_rd_a, dep_rd_b;
   logic              out_free;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [W_W-1:0]    rsp_path_min_ff, rsp_path_min_in;

   assign tbl_rd_a = tbl_rd_a_raw;
   assign tbl_rd_b = tbl_rd_b_raw;

   // lifting table: ancestor and path minimum per node and level
   tpml_ram #(.WIDTH(ENTRY_W), .DEPTH(TBL_DEPTH)) u_tbl (
      .clock   (clock),
      .we      (tbl.we),
      .waddr   (tbl.waddr),
      .wdata   (tbl.wdata),
      .raddr_a (tbl.ra),
      .raddr_b (tbl.rb),
      .rdata_a (tbl_rd_a_raw),
      .rdata_b (tbl_rd_b_raw)
   );

   // node depths
   tpml_ram #(.WIDTH(DEP_W), .DEPTH(NODES)) u_dep (
      .clock   (clock),
      .we      (dep.we),
      .waddr   (dep.waddr),
      .wdata   (dep.wdata),
      .raddr_a (dep.ra),
      .raddr_b (dep.rb),
      .rdata_a (dep_rd_a),
      .rdata_b (dep_rd_b)
   );

   tpml_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_mode       (req_mode),
      .req_node       (req_node),
      .req_other_node (req_other_node),
      .req_weight     (req_weight),
      .req_stall      (req_stall),
      .out_free       (out_free),
      .push           (push),
      .tbl            (tbl),
      .tbl_rd_a       (tbl_rd_a),
      .tbl_rd_b       (tbl_rd_b),
      .dep            (dep),
      .dep_rd_a       (dep_rd_a),
      .dep_rd_b       (dep_rd_b)
   );

   // output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_path_min_in = rsp_path_min_ff;
      if (push.valid && out_free) begin
         rsp_valid_in    = 1'b1;
         rsp_path_min_in = push.path_min;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_path_min_ff <= rsp_path_min_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_path_min = rsp_path_min_ff;

`ifndef SYNTHESIS
   // depth clear pass keeps the input closed right after reset
   a_clr_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input open during depth clear");

   // one item at a time: an accepted beat closes the input
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open right after an accepted beat");

   // a result handed to the output register shows up unchanged
   a_push: assert property (@(posedge clock) disable iff (reset)
      (push.valid && out_free) |=> (rsp_valid && rsp_path_min == $past(push.path_min)))
      else $error("result lost at output register");

   // a path minimum never exceeds the no-edge value
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_path_min <= NO_EDGE))
      else $error("path minimum out of range");
`endif

endmodule
